[rtl/pcarc_pkg.sv]
// pcarc_pkg: shared types, register indexes and constants of the pitch cascade controller
// no dependencies; imported by every module of the block

package pcarc_pkg;

    // shared multiplier operand widths
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 27;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int ANGLE_W  = 24;
    localparam int ERR_W    = 25;
    localparam int GAIN_W   = 16;
    localparam int K_W      = 26;   // gain times the 0.01 scale
    localparam int ISUM_W   = 24;
    localparam int ILIM_W   = 23;
    localparam int OLIM_W   = 31;
    localparam int ACC_W    = 43;
    localparam int OUTER_W  = 32;
    localparam int DIFF_W   = 34;
    localparam int DRIVE_W  = 16;
    localparam int GOFF_W   = 10;
    localparam int GENT_W   = 9;

    localparam int Q16_SHIFT = 16;

    localparam logic [9:0]           Q16_SCALE    = 10'd655;
    localparam logic signed [16:0]   INNER_SAT    = 17'sd32000;
    localparam logic signed [GOFF_W-1:0] GRAVITY_BASE = -10'sd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_P   = 3'd0,
        CFG_OUTER_I   = 3'd1,
        CFG_OUTER_D   = 3'd2,
        CFG_INNER_P   = 3'd3,
        CFG_ILIMIT    = 3'd4,
        CFG_OLIMIT    = 3'd5,
        CFG_ISHIFT    = 3'd6,
        CFG_GRAV_ON   = 3'd7
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] RST_OUTER_P = 16'd185;
    localparam logic [GAIN_W-1:0] RST_OUTER_I = 16'd50;
    localparam logic [GAIN_W-1:0] RST_OUTER_D = 16'd0;
    localparam logic [GAIN_W-1:0] RST_INNER_P = 16'd60;
    localparam logic [ILIM_W-1:0] RST_ILIMIT  = 23'd1280000;
    localparam logic [OLIM_W-1:0] RST_OLIMIT  = 31'h7FFF_FFFF;
    localparam logic [2:0]        RST_ISHIFT  = 3'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KI,
        S_KD,
        S_KIN,
        S_P,
        S_I,
        S_D,
        S_DSUM,
        S_CLAMP,
        S_DIFF,
        S_INNER,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_KI,
        MUL_KD,
        MUL_KIN,
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_INNER
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_err;
        logic     ld_ki;
        logic     ld_kd;
        logic     ld_kin;
        logic     upd_integ;
        logic     ld_p;
        logic     add_term;
        logic     ld_outer;
        logic     ld_diff;
        logic     ld_result;
    } t_ctrl;

    // step table on whole degrees of attitude
    function automatic logic [GENT_W-1:0] gravity_entry(input logic [ANGLE_W-1:0] deg);
        logic [GENT_W-1:0] e;
        if (deg < 24'd2)       e = 9'd0;
        else if (deg < 24'd4)  e = 9'd86;
        else if (deg < 24'd6)  e = 9'd130;
        else if (deg < 24'd8)  e = 9'd173;
        else if (deg < 24'd10) e = 9'd216;
        else                   e = 9'd260;
        return e;
    endfunction

endpackage

[rtl/pcarc_mul.sv]
// pcarc_mul: shared signed multiplier with registered product
// depends on pcarc_pkg for operand widths

module pcarc_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [pcarc_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [pcarc_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [pcarc_pkg::PROD_W-1:0]   o_prod
);
    import pcarc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/pcarc_ctrl.sv]
// pcarc_ctrl: sequencer that steps one tick through the shared multiplier
// depends on pcarc_pkg for the state, operand select and control struct types

module pcarc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_busy,
    output pcarc_pkg::t_ctrl  o_ctrl
);
    import pcarc_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ctrl    = '0;
        ctrl.mul_sel = MUL_KI;
        case (r_state)
            S_IDLE: begin
                ctrl.in_ready = 1'b1;
                if (i_in_valid) n_state = S_KI;
            end
            S_KI: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_KI;
                ctrl.ld_err  = 1'b1;
                n_state      = S_KD;
            end
            S_KD: begin
                ctrl.ld_ki     = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = MUL_KD;
                ctrl.upd_integ = 1'b1;
                n_state        = S_KIN;
            end
            S_KIN: begin
                ctrl.ld_kd   = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_KIN;
                n_state      = S_P;
            end
            S_P: begin
                ctrl.ld_kin  = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_P;
                n_state      = S_I;
            end
            S_I: begin
                ctrl.ld_p    = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_I;
                n_state      = S_D;
            end
            S_D: begin
                ctrl.add_term = 1'b1;
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = MUL_D;
                n_state       = S_DSUM;
            end
            S_DSUM: begin
                ctrl.add_term = 1'b1;
                n_state       = S_CLAMP;
            end
            S_CLAMP: begin
                ctrl.ld_outer = 1'b1;
                n_state       = S_DIFF;
            end
            S_DIFF: begin
                ctrl.ld_diff = 1'b1;
                n_state      = S_INNER;
            end
            S_INNER: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_INNER;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_out_busy) begin
                    ctrl.ld_result = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctrl = ctrl;

endmodule

[rtl/pitch_cascade_angle_rate_controller_top.sv]
// Pitch cascade angle/rate controller, one beat in and one beat out per control tick.
// An accepted tick runs through a sequencer around a single shared 34x27 signed
// multiplier: three gain prescales, the P, I and D products and the inner-loop
// product are issued one after another; the result is then loaded into the output
// register once that register is free, and the input side is ready again after
// that load. The result sits in an output register, so a new tick is accepted
// while the previous result waits to be taken.
// Configuration writes take effect at once and must be issued while idle.
// depends on pcarc_pkg, pcarc_ctrl and pcarc_mul

module pitch_cascade_angle_rate_controller_top #(
    parameter int ANGLE_FRACTION_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_we,
    input  logic [pcarc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pcarc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_enable,
    input  logic signed [pcarc_pkg::ANGLE_W-1:0]    i_target_angle,
    input  logic signed [pcarc_pkg::ANGLE_W-1:0]    i_measured_angle,
    input  logic signed [pcarc_pkg::ANGLE_W-1:0]    i_attitude_angle,
    input  logic signed [pcarc_pkg::ANGLE_W-1:0]    i_angular_rate,
    // output channel
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [pcarc_pkg::DRIVE_W-1:0]    o_drive,
    output logic signed [pcarc_pkg::OUTER_W-1:0]    o_outer_output
);
    import pcarc_pkg::*;

    localparam int INNER_SHIFT = Q16_SHIFT + ANGLE_FRACTION_BITS;

    // configuration registers
    logic [GAIN_W-1:0] r_outer_p;
    logic [GAIN_W-1:0] r_outer_i;
    logic [GAIN_W-1:0] r_outer_d;
    logic [GAIN_W-1:0] r_inner_p;
    logic [ILIM_W-1:0] r_ilimit;
    logic [OLIM_W-1:0] r_olimit;
    logic [2:0]        r_ishift;
    logic              r_grav_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_p <= RST_OUTER_P;
            r_outer_i <= RST_OUTER_I;
            r_outer_d <= RST_OUTER_D;
            r_inner_p <= RST_INNER_P;
            r_ilimit  <= RST_ILIMIT;
            r_olimit  <= RST_OLIMIT;
            r_ishift  <= RST_ISHIFT;
            r_grav_on <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OUTER_P: r_outer_p <= i_cfg_data[GAIN_W-1:0];
                CFG_OUTER_I: r_outer_i <= i_cfg_data[GAIN_W-1:0];
                CFG_OUTER_D: r_outer_d <= i_cfg_data[GAIN_W-1:0];
                CFG_INNER_P: r_inner_p <= i_cfg_data[GAIN_W-1:0];
                CFG_ILIMIT:  r_ilimit  <= i_cfg_data[ILIM_W-1:0];
                CFG_OLIMIT:  r_olimit  <= i_cfg_data[OLIM_W-1:0];
                CFG_ISHIFT:  r_ishift  <= i_cfg_data[2:0];
                CFG_GRAV_ON: r_grav_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    t_ctrl ctrl;
    logic  out_busy;

    pcarc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_out_busy (out_busy),
        .o_ctrl     (ctrl)
    );

    assign o_ready = ctrl.in_ready;
    wire accept = i_valid && ctrl.in_ready;

    // captured tick
    logic                      r_enable;
    logic signed [ANGLE_W-1:0] r_tgt;
    logic signed [ANGLE_W-1:0] r_meas;
    logic signed [ANGLE_W-1:0] r_att;
    logic signed [ANGLE_W-1:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_enable <= i_enable;
            r_tgt    <= i_target_angle;
            r_meas   <= i_measured_angle;
            r_att    <= i_attitude_angle;
            r_rate   <= i_angular_rate;
        end
    end

    // working registers
    logic signed [ERR_W-1:0]   r_err;
    logic        [K_W-1:0]     r_ki;
    logic        [K_W-1:0]     r_kd;
    logic        [K_W-1:0]     r_kin;
    logic signed [ISUM_W-1:0]  r_isum;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [OUTER_W-1:0] r_outer;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [GOFF_W-1:0]  r_goff;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            MUL_KI: begin
                mul_a = MUL_A_W'({1'b0, r_outer_i});
                mul_b = MUL_B_W'({1'b0, Q16_SCALE});
            end
            MUL_KD: begin
                mul_a = MUL_A_W'({1'b0, r_outer_d});
                mul_b = MUL_B_W'({1'b0, Q16_SCALE});
            end
            MUL_KIN: begin
                mul_a = MUL_A_W'({1'b0, r_inner_p});
                mul_b = MUL_B_W'({1'b0, Q16_SCALE});
            end
            MUL_P: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'({1'b0, r_outer_p});
            end
            MUL_I: begin
                mul_a = MUL_A_W'(r_isum);
                mul_b = MUL_B_W'({1'b0, r_ki});
            end
            MUL_D: begin
                mul_a = MUL_A_W'(r_rate);
                mul_b = MUL_B_W'({1'b0, r_kd});
            end
            MUL_INNER: begin
                mul_a = r_diff;
                mul_b = MUL_B_W'({1'b0, r_kin});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pcarc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // integral update: add the shifted error and saturate
    logic signed [ISUM_W+1:0] isum_sum;
    logic signed [ISUM_W+1:0] ilim_pos;
    logic signed [ISUM_W+1:0] ilim_neg;
    logic signed [ISUM_W-1:0] n_isum;

    always_comb begin
        isum_sum = (ISUM_W+2)'(r_isum) + (ISUM_W+2)'(r_err >>> r_ishift);
        ilim_pos = (ISUM_W+2)'({1'b0, r_ilimit});
        ilim_neg = -ilim_pos;
        if (isum_sum > ilim_pos)      n_isum = ISUM_W'(ilim_pos);
        else if (isum_sum < ilim_neg) n_isum = ISUM_W'(ilim_neg);
        else                          n_isum = ISUM_W'(isum_sum);
    end

    // gravity offset from the whole-degree attitude
    logic        [ANGLE_W-1:0] att_mag;
    logic        [GENT_W-1:0]  g_entry;
    logic signed [GOFF_W-1:0]  n_goff;

    always_comb begin
        att_mag = r_att[ANGLE_W-1] ? ANGLE_W'(-r_att) : ANGLE_W'(r_att);
        g_entry = gravity_entry(att_mag >> ANGLE_FRACTION_BITS);
        if (!r_att[ANGLE_W-1] && (r_att != '0)) begin
            n_goff = GRAVITY_BASE - GOFF_W'({1'b0, g_entry});
        end else begin
            n_goff = GRAVITY_BASE + GOFF_W'({1'b0, g_entry});
        end
    end

    // outer clamp
    logic signed [ACC_W-1:0]   olim_pos;
    logic signed [OUTER_W-1:0] n_outer;

    always_comb begin
        olim_pos = ACC_W'({1'b0, r_olimit});
        if (r_acc > olim_pos)       n_outer = OUTER_W'(olim_pos);
        else if (r_acc < -olim_pos) n_outer = OUTER_W'(-olim_pos);
        else                        n_outer = OUTER_W'(r_acc);
    end

    wire signed [PROD_W-1:0] term_q16 = prod >>> Q16_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
        end else if (ctrl.upd_integ) begin
            r_isum <= n_isum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_err) begin
            r_err  <= ERR_W'(r_tgt) - ERR_W'(r_meas);
            r_goff <= n_goff;
        end
        if (ctrl.ld_ki)  r_ki  <= prod[K_W-1:0];
        if (ctrl.ld_kd)  r_kd  <= prod[K_W-1:0];
        if (ctrl.ld_kin) r_kin <= prod[K_W-1:0];
        if (ctrl.ld_p) begin
            r_acc <= prod[ACC_W-1:0];
        end else if (ctrl.add_term) begin
            r_acc <= r_acc + term_q16[ACC_W-1:0];
        end
        if (ctrl.ld_outer) r_outer <= n_outer;
        if (ctrl.ld_diff)  r_diff  <= DIFF_W'(r_outer) - DIFF_W'(r_rate);
    end

    // inner saturation, offset and enable
    logic signed [PROD_W-1:0]  inner_full;
    logic signed [16:0]        inner_sat;
    logic signed [16:0]        drive_sum;
    logic signed [DRIVE_W-1:0] n_drive;

    always_comb begin
        inner_full = prod >>> INNER_SHIFT;
        if (inner_full > PROD_W'(INNER_SAT))       inner_sat = INNER_SAT;
        else if (inner_full < -PROD_W'(INNER_SAT)) inner_sat = -INNER_SAT;
        else                                       inner_sat = inner_full[16:0];
        drive_sum = inner_sat + (r_grav_on ? 17'(r_goff) : 17'sd0);
        n_drive   = r_enable ? drive_sum[DRIVE_W-1:0] : '0;
    end

    // output register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [OUTER_W-1:0] r_outer_out;

    assign out_busy = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.ld_result) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_result) begin
            r_drive     <= n_drive;
            r_outer_out <= r_outer;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_drive        = r_drive;
    assign o_outer_output = r_outer_out;

endmodule

[rtl/pcarc_chk.sv]
// pcarc_chk: port-level checks on the pitch cascade controller, bound to its top level
// depends on pcarc_pkg for port widths

module pcarc_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [pcarc_pkg::DRIVE_W-1:0]  o_drive,
    input logic signed [pcarc_pkg::OUTER_W-1:0]  o_outer_output
);
    import pcarc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_drive) && $stable(o_outer_output)))
        else $error("result beat changed while stalled");

    // one tick at a time: input side closes after an accepted beat
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted again while a tick is in flight");

    // drive stays within inner saturation plus gravity offset
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_drive <= 16'sd32160) && (o_drive >= -16'sd32360)))
        else $error("drive out of range");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind pitch_cascade_angle_rate_controller_top pcarc_chk u_pcarc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_drive        (o_drive),
    .o_outer_output (o_outer_output)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench for pitch_cascade_angle_rate_controller_top: self-checking, with its own tick predictor
// a queue-fed driver and a result monitor run under random idling; depends on pcarc_pkg and the rtl

module testbench;
    import pcarc_pkg::*;

    localparam int     FRAC_BITS     = 8;
    localparam longint SCALE_001     = 655;     // 0.01 in q16
    localparam longint DRIVE_SAT     = 32000;
    localparam longint GRAV_BASE     = -100;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     LONG_HOLD     = 300;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     PHASE_TICKS   = 215;
    localparam int     MAX_PRINTS    = 30;

    typedef struct {
        logic                      enable;
        logic signed [ANGLE_W-1:0] target;
        logic signed [ANGLE_W-1:0] measured;
        logic signed [ANGLE_W-1:0] attitude;
        logic signed [ANGLE_W-1:0] rate;
    } t_tick;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [OUTER_W-1:0] outer;
    } t_tick_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic                       i_enable = 1'b0;
    logic signed [ANGLE_W-1:0]  i_target_angle = '0;
    logic signed [ANGLE_W-1:0]  i_measured_angle = '0;
    logic signed [ANGLE_W-1:0]  i_attitude_angle = '0;
    logic signed [ANGLE_W-1:0]  i_angular_rate = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [DRIVE_W-1:0]  o_drive;
    logic signed [OUTER_W-1:0]  o_outer_output;

    // predictor copy of the register file and the integrator
    longint gain_op, gain_oi, gain_od, gain_ip;
    longint lim_integ, lim_outer, integ_shift, grav_on;
    longint integ_acc;

    t_tick        tick_backlog[$];
    t_tick_result drive_expect_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_kick = 1'b0;
    int  hold_left = 0;
    int  mismatch_cnt = 0;
    int  accepted_ticks = 0;
    int  results_seen = 0;
    int  settings_used = 0;
    int  cycles = 0;

    pitch_cascade_angle_rate_controller_top #(
        .ANGLE_FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_enable         (i_enable),
        .i_target_angle   (i_target_angle),
        .i_measured_angle (i_measured_angle),
        .i_attitude_angle (i_attitude_angle),
        .i_angular_rate   (i_angular_rate),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_drive          (o_drive),
        .o_outer_output   (o_outer_output)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     drive_expect_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // step table on whole degrees, sign opposite to the attitude
    function automatic longint gravity_offset(longint att);
        longint mag;
        longint deg;
        longint step;
        mag = (att < 0) ? -att : att;
        deg = mag >>> FRAC_BITS;
        if (deg < 2)       step = 0;
        else if (deg < 4)  step = 86;
        else if (deg < 6)  step = 130;
        else if (deg < 8)  step = 173;
        else if (deg < 10) step = 216;
        else               step = 260;
        return GRAV_BASE + ((att > 0) ? -step : step);
    endfunction

    function automatic t_tick_result pitch_tick_predict(t_tick t);
        t_tick_result r;
        longint err;
        longint rate;
        longint p_term;
        longint i_term;
        longint d_term;
        longint outer;
        longint inner;
        longint drive;
        err    = longint'(t.target) - longint'(t.measured);
        rate   = longint'(t.rate);
        p_term = err * gain_op;
        integ_acc = clamp_sym(integ_acc + (err >>> integ_shift), lim_integ);
        i_term = (integ_acc * gain_oi * SCALE_001) >>> 16;
        d_term = (rate * gain_od * SCALE_001) >>> 16;
        outer  = clamp_sym(p_term + i_term + d_term, lim_outer);
        inner  = ((outer - rate) * gain_ip * SCALE_001) >>> (16 + FRAC_BITS);
        inner  = clamp_sym(inner, DRIVE_SAT);
        drive  = 0;
        if (t.enable) begin
            drive = inner;
            if (grav_on != 0)
                drive += gravity_offset(longint'(t.attitude));
        end
        r.drive = drive[DRIVE_W-1:0];
        r.outer = outer[OUTER_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("mismatch at result %0d (cycle %0d): %s got %0d expected %0d",
                     results_seen, cycles, what, got, want);
        mismatch_cnt++;
    endtask

    // input side: predict on acceptance, then offer the next beat or idle
    always @(posedge i_clk) begin : offer_ticks
        t_tick seen;
        t_tick nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                seen.enable   = i_enable;
                seen.target   = i_target_angle;
                seen.measured = i_measured_angle;
                seen.attitude = i_attitude_angle;
                seen.rate     = i_angular_rate;
                drive_expect_q.push_back(pitch_tick_predict(seen));
                accepted_ticks++;
            end
            if (!i_valid || o_ready) begin
                if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = tick_backlog.pop_front();
                    i_valid          <= 1'b1;
                    i_enable         <= nxt.enable;
                    i_target_angle   <= nxt.target;
                    i_measured_angle <= nxt.measured;
                    i_attitude_angle <= nxt.attitude;
                    i_angular_rate   <= nxt.rate;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin : sink_ready
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_kick)
                hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_tick_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (drive_expect_q.size() == 0) begin
                report_mismatch("unexpected beat, drive", longint'(o_drive), 0);
            end else begin
                want = drive_expect_q.pop_front();
                if (o_drive !== want.drive)
                    report_mismatch("drive", longint'(o_drive), longint'(want.drive));
                if (o_outer_output !== want.outer)
                    report_mismatch("outer_output", longint'(o_outer_output),
                                    longint'(want.outer));
            end
            results_seen++;
        end
    end

    task automatic write_reg(t_cfg_idx idx, longint val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_OUTER_P: gain_op     = val & 64'hFFFF;
            CFG_OUTER_I: gain_oi     = val & 64'hFFFF;
            CFG_OUTER_D: gain_od     = val & 64'hFFFF;
            CFG_INNER_P: gain_ip     = val & 64'hFFFF;
            CFG_ILIMIT:  lim_integ   = val & 64'h7F_FFFF;
            CFG_OLIMIT:  lim_outer   = val & 64'h7FFF_FFFF;
            CFG_ISHIFT:  integ_shift = val & 64'h7;
            CFG_GRAV_ON: grav_on     = val & 64'h1;
            default: ;
        endcase
    endtask

    task automatic apply_setting(longint op, longint oi, longint od, longint ip,
                                 longint il, longint ol, longint sh, longint gr);
        write_reg(CFG_OUTER_P, op);
        write_reg(CFG_OUTER_I, oi);
        write_reg(CFG_OUTER_D, od);
        write_reg(CFG_INNER_P, ip);
        write_reg(CFG_ILIMIT, il);
        write_reg(CFG_OLIMIT, ol);
        write_reg(CFG_ISHIFT, sh);
        write_reg(CFG_GRAV_ON, gr);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        while (tick_backlog.size() != 0 || i_valid || drive_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic long_hold();
        @(posedge i_clk);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
    endtask

    function automatic t_tick mk_tick(logic en, int tgt, int meas, int att, int rate);
        t_tick t;
        t.enable   = en;
        t.target   = ANGLE_W'(tgt);
        t.measured = ANGLE_W'(meas);
        t.attitude = ANGLE_W'(att);
        t.rate     = ANGLE_W'(rate);
        return t;
    endfunction

    // mostly tracking ticks with small errors so outputs stay off the rails
    function automatic t_tick random_tick();
        t_tick t;
        int meas;
        int err;
        if ($urandom_range(0, 9) < 2) begin
            t.enable   = 1'($urandom);
            t.target   = ANGLE_W'($urandom);
            t.measured = ANGLE_W'($urandom);
            t.attitude = ANGLE_W'($urandom);
            t.rate     = ANGLE_W'($urandom);
        end else begin
            meas = int'($urandom_range(0, 8388607)) - 4194304;
            err  = int'($urandom) >>> $urandom_range(9, 31);
            t.enable   = ($urandom_range(0, 99) < 85);
            t.measured = ANGLE_W'(meas);
            t.target   = ANGLE_W'(meas + err);
            t.rate     = ANGLE_W'(int'($urandom) >>> $urandom_range(9, 31));
            if ($urandom_range(0, 3) != 0)
                t.attitude = ANGLE_W'(int'($urandom_range(0, 6000)) - 3000);
            else
                t.attitude = ANGLE_W'($urandom);
        end
        return t;
    endfunction

    initial begin : run_phases
        gain_op = longint'(RST_OUTER_P);
        gain_oi = longint'(RST_OUTER_I);
        gain_od = longint'(RST_OUTER_D);
        gain_ip = longint'(RST_INNER_P);
        lim_integ = longint'(RST_ILIMIT);
        lim_outer = longint'(RST_OLIMIT);
        integ_shift = longint'(RST_ISHIFT);
        grav_on = 0;
        integ_acc = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 77;

        // directed: field extremes, disabled ticks, gravity steps, clamps
        apply_setting(185, 50, 300, 60, 1280000, 50000000, 1, 1);
        tick_backlog.push_back(mk_tick(1, 0, 0, 0, 0));
        tick_backlog.push_back(mk_tick(1, 8388607, -8388608, 0, 0));
        tick_backlog.push_back(mk_tick(1, -8388608, 8388607, 0, 0));
        tick_backlog.push_back(mk_tick(0, 8388607, -8388608, 512, 8388607));
        tick_backlog.push_back(mk_tick(1, 100, 0, 255, -8388608));
        tick_backlog.push_back(mk_tick(1, -100, 0, -255, 8388607));
        tick_backlog.push_back(mk_tick(1, 40, 0, 511, 0));
        tick_backlog.push_back(mk_tick(1, 40, 0, 512, 0));
        tick_backlog.push_back(mk_tick(1, 40, 0, -512, 0));
        tick_backlog.push_back(mk_tick(1, -40, 0, 1023, 0));
        tick_backlog.push_back(mk_tick(1, -40, 0, 1024, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, -1535, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, 1536, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, 2047, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, -2048, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, 2559, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, 2560, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, -2560, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, 8388607, 0));
        tick_backlog.push_back(mk_tick(1, 20, 0, -8388608, 0));
        tick_backlog.push_back(mk_tick(1, 0, 0, -1, 0));
        tick_backlog.push_back(mk_tick(1, 3, 0, 0, 0));
        tick_backlog.push_back(mk_tick(1, -3, 0, 0, -7));
        tick_backlog.push_back(mk_tick(0, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 1; ph <= 6; ph++) begin
            if (ph <= 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 77;
            end else if (ph <= 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: apply_setting(longint'(RST_OUTER_P), longint'(RST_OUTER_I),
                                 longint'(RST_OUTER_D), longint'(RST_INNER_P),
                                 longint'(RST_ILIMIT), longint'(RST_OLIMIT),
                                 longint'(RST_ISHIFT), 0);
                2: apply_setting(65535, 65535, 65535, 65535, 8388607, 2147483647, 7, 1);
                // zero limits pin the integral and the outer output
                3: apply_setting(0, 0, 0, 65535, 0, 0, 0, 1);
                4: apply_setting(longint'($urandom_range(0, 65535)),
                                 longint'($urandom_range(0, 65535)),
                                 longint'($urandom_range(0, 65535)),
                                 longint'($urandom_range(0, 65535)),
                                 longint'($urandom_range(0, 8388607)),
                                 longint'($urandom_range(0, 2147483647)),
                                 longint'($urandom_range(0, 7)),
                                 longint'($urandom_range(0, 1)));
                5: apply_setting(longint'($urandom_range(0, 400)),
                                 longint'($urandom_range(0, 400)),
                                 longint'($urandom_range(0, 400)),
                                 longint'($urandom_range(0, 400)),
                                 longint'($urandom_range(0, 200000)),
                                 longint'($urandom_range(0, 4000000)),
                                 longint'($urandom_range(0, 7)), 1);
                default: apply_setting(longint'($urandom_range(0, 65535)),
                                       longint'($urandom_range(0, 65535)),
                                       longint'($urandom_range(0, 65535)), 0,
                                       8388607, longint'($urandom_range(0, 2147483647)),
                                       longint'($urandom_range(0, 7)), 1);
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
                tick_backlog.push_back(random_tick());
            // back-pressure while the sender keeps offering beats
            if (ph >= 5)
                long_hold();
            wait_drained();
        end

        if (drive_expect_q.size() != 0)
            report_mismatch("results left over", longint'(drive_expect_q.size()), 0);
        $display("covered %0d ticks under %0d register settings, %0d result beats compared",
                 accepted_ticks, settings_used, results_seen);
        $display("included gravity steps, integral and outer clamps, disabled ticks, stalls");
        if (mismatch_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/pcarc_pkg.sv
rtl/pcarc_mul.sv
rtl/pcarc_ctrl.sv
rtl/pitch_cascade_angle_rate_controller_top.sv
rtl/pcarc_chk.sv
tb/testbench.sv
